// ===== src/tsca_pkg.sv =====
// tsca_pkg: shared types, constants and helpers for the three-state cell grid
// depends on nothing; imported by the grid top level and its checker
package tsca_pkg;

    // grid geometry
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int DIM_W    = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1);
    localparam int POS_W    = (DIM_W > 7) ? DIM_W : 7;
    localparam int ROW_BITS = 2 * MAX_COLS;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 2'd2;

    typedef logic [1:0]          cell_t;
    typedef logic [ROW_BITS-1:0] row_word_t;
    typedef logic [POS_W-1:0]    pos_t;

    // cell states
    localparam cell_t CELL_OFF    = 2'd0;
    localparam cell_t CELL_FIRING = 2'd1;
    localparam cell_t CELL_DYING  = 2'd2;

    // commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // intensity levels
    localparam logic [15:0] FULL_LEVEL = 16'hFFFF;
    localparam logic [15:0] DIM_LEVEL  = 16'h5555;

    // intensity of a cell state
    function automatic logic [15:0] level_of(input cell_t s);
        logic [15:0] lvl;
        lvl = 16'd0;
        if (s == CELL_FIRING)
        begin
            lvl = FULL_LEVEL;
        end
        else if (s == CELL_DYING)
        begin
            lvl = DIM_LEVEL;
        end
        return lvl;
    endfunction

    // size in use: zero acts as one, above the maximum acts as the maximum
    function automatic pos_t eff_dim(input logic [CFG_DATA_W-1:0] v, input pos_t maxv);
        pos_t ve;
        ve = pos_t'(v);
        if (ve == pos_t'(0))
        begin
            ve = pos_t'(1);
        end
        else if (ve > maxv)
        begin
            ve = maxv;
        end
        return ve;
    endfunction

endpackage

// ===== src/tsca_ram.sv =====
// tsca_ram: generic simple dual-port ram, one write port and one registered read port
// depends on nothing
module tsca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/three_state_cell_automaton_grid.sv =====
// three_state_cell_automaton_grid: three-state cell grid with write, read and advance commands
// depends on tsca_pkg and tsca_ram (two row-wide banks that swap roles on each advance)
//
//  channel   handshake          payload                                  direction
//  command   start / busy       command, col, row, cell_value            in
//  result    done (one cycle)   cell_state, intensity, changed, in_range out
//  config    cfg_we             cfg_index, cfg_data                      in
//
// write or read: busy for one cycle after the beat, then the result beat
// a command with nothing to do (out of range, unused code) has its result in the next cycle
// advance: for each stored row, three row reads on the single read port (up, mid, down),
// capture, then compute and write; all MAX_ROWS rows are passed, then the result beat
// after reset a clearing pass writes bank 0 one row a cycle, all MAX_ROWS rows, with busy high
// the receiver cannot stall: every result beat (done) is high for exactly one cycle
module three_state_cell_automaton_grid
    import tsca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            command,
    input  logic [5:0]            col,
    input  logic [5:0]            row,
    input  logic [1:0]            cell_value,
    output logic                  done,
    output logic [1:0]            cell_state,
    output logic [15:0]           intensity,
    output logic                  changed,
    output logic                  in_range,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CELL  = 2'd2;
    localparam logic [1:0] ST_ADV   = 2'd3;

    // advance phases within one row
    localparam logic [2:0] PH_UP   = 3'd0;
    localparam logic [2:0] PH_MID  = 3'd1;
    localparam logic [2:0] PH_DN   = 3'd2;
    localparam logic [2:0] PH_CAP  = 3'd3;
    localparam logic [2:0] PH_CALC = 3'd4;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);

    // control registers
    logic [1:0]            state_reg, state_next;
    logic [2:0]            phase_reg, phase_next;
    logic [ROW_W-1:0]      row_cnt_reg, row_cnt_next;
    logic                  bank_reg, bank_next;
    logic                  chg_reg, chg_next;
    logic [CFG_DATA_W-1:0] cfg_w_reg, cfg_w_next;
    logic [CFG_DATA_W-1:0] cfg_h_reg, cfg_h_next;
    logic                  cfg_wrap_reg, cfg_wrap_next;
    logic                  done_reg, done_next;

    // payload registers
    logic [1:0]            cmd_reg, cmd_next;
    logic [COL_W-1:0]      col_reg, col_next;
    cell_t                 val_reg, val_next;
    row_word_t             up_reg, up_next;
    row_word_t             mid_reg, mid_next;
    row_word_t             dn_reg, dn_next;
    cell_t                 cell_state_reg, cell_state_next;
    logic [15:0]           intensity_reg, intensity_next;
    logic                  changed_reg, changed_next;
    logic                  in_range_reg, in_range_next;

    // memory ports
    logic                  rd_en;
    logic [ROW_W-1:0]      rd_addr;
    row_word_t             rd_data;
    row_word_t             rdata0;
    row_word_t             rdata1;
    logic                  wr_en;
    logic                  wr_bank;
    logic [ROW_W-1:0]      wr_addr;
    row_word_t             wr_data;

    // geometry
    pos_t                  eff_w;
    pos_t                  eff_h;
    pos_t                  w_last;
    pos_t                  h_last;
    pos_t                  col_pos;
    pos_t                  row_pos;
    pos_t                  y_pos;
    logic                  in_grid;
    logic                  y_used;
    logic                  up_ok;
    logic                  dn_ok;
    logic [ROW_W-1:0]      up_idx;
    logic [ROW_W-1:0]      dn_idx;
    logic [COL_W-1:0]      wl;

    // row compute
    logic [MAX_COLS-1:0]   fire_u;
    logic [MAX_COLS-1:0]   fire_m;
    logic [MAX_COLS-1:0]   fire_d;
    logic [MAX_COLS:0]     lo_u;
    logic [MAX_COLS:0]     lo_m;
    logic [MAX_COLS:0]     lo_d;
    logic [MAX_COLS:0]     hi_u;
    logic [MAX_COLS:0]     hi_m;
    logic [MAX_COLS:0]     hi_d;
    row_word_t             new_row;
    logic                  row_chg;
    cell_t                 stored_val;
    cell_t                 read_val;
    logic                  accept;

    // two banks of rows, one cell pair of bits per column
    tsca_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_ROWS)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_en & ~wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata0)
    );

    tsca_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_ROWS)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_en & wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata1)
    );

    assign rd_data = bank_reg ? rdata1 : rdata0;

    // size in use and bounds checks
    assign eff_w   = eff_dim(cfg_w_reg, pos_t'(MAX_COLS));
    assign eff_h   = eff_dim(cfg_h_reg, pos_t'(MAX_ROWS));
    assign w_last  = eff_w - pos_t'(1);
    assign h_last  = eff_h - pos_t'(1);
    assign wl      = w_last[COL_W-1:0];
    assign col_pos = pos_t'(col);
    assign row_pos = pos_t'(row);
    assign in_grid = (col_pos < eff_w) && (row_pos < eff_h);

    // neighbour rows of the row being advanced
    assign y_pos  = pos_t'(row_cnt_reg);
    assign y_used = y_pos < eff_h;

    always_comb
    begin
        if (row_cnt_reg == '0)
        begin
            up_ok  = cfg_wrap_reg;
            up_idx = h_last[ROW_W-1:0];
        end
        else
        begin
            up_ok  = 1'b1;
            up_idx = row_cnt_reg - ROW_W'(1);
        end
        if ((y_pos + pos_t'(1)) < eff_h)
        begin
            dn_ok  = 1'b1;
            dn_idx = row_cnt_reg + ROW_W'(1);
        end
        else
        begin
            dn_ok  = cfg_wrap_reg;
            dn_idx = '0;
        end
    end

    // firing masks of the three window rows
    always_comb
    begin
        for (int x = 0; x < MAX_COLS; x++)
        begin
            fire_u[x] = (up_reg[2*x +: 2]  == CELL_FIRING);
            fire_m[x] = (mid_reg[2*x +: 2] == CELL_FIRING);
            fire_d[x] = (dn_reg[2*x +: 2]  == CELL_FIRING);
        end
    end

    // shifted masks: lo bit x is column x-1, hi bit x+1 is column x+1
    assign lo_u = {fire_u, 1'b0};
    assign lo_m = {fire_m, 1'b0};
    assign lo_d = {fire_d, 1'b0};
    assign hi_u = {1'b0, fire_u};
    assign hi_m = {1'b0, fire_m};
    assign hi_d = {1'b0, fire_d};

    // next generation of the middle row, all columns side by side
    always_comb
    begin
        logic  l_u;
        logic  l_m;
        logic  l_d;
        logic  r_u;
        logic  r_m;
        logic  r_d;
        logic  x_used;
        logic [3:0] cnt;
        cell_t now;
        cell_t res;
        l_u     = 1'b0;
        l_m     = 1'b0;
        l_d     = 1'b0;
        r_u     = 1'b0;
        r_m     = 1'b0;
        r_d     = 1'b0;
        x_used  = 1'b0;
        cnt     = '0;
        now     = CELL_OFF;
        res     = CELL_OFF;
        new_row = '0;
        row_chg = 1'b0;
        for (int x = 0; x < MAX_COLS; x++)
        begin
            // left neighbour column
            if (x == 0)
            begin
                l_u = cfg_wrap_reg & fire_u[wl];
                l_m = cfg_wrap_reg & fire_m[wl];
                l_d = cfg_wrap_reg & fire_d[wl];
            end
            else
            begin
                l_u = lo_u[x];
                l_m = lo_m[x];
                l_d = lo_d[x];
            end
            // right neighbour column
            if (pos_t'(x + 1) < eff_w)
            begin
                r_u = hi_u[x+1];
                r_m = hi_m[x+1];
                r_d = hi_d[x+1];
            end
            else
            begin
                r_u = cfg_wrap_reg & fire_u[0];
                r_m = cfg_wrap_reg & fire_m[0];
                r_d = cfg_wrap_reg & fire_d[0];
            end
            cnt = 4'(l_u) + 4'(fire_u[x]) + 4'(r_u) + 4'(l_m) + 4'(r_m)
                + 4'(l_d) + 4'(fire_d[x]) + 4'(r_d);
            now    = mid_reg[2*x +: 2];
            x_used = pos_t'(x) < eff_w;
            if (!(x_used && y_used))
            begin
                res = now;
            end
            else if (now == CELL_FIRING)
            begin
                res = CELL_DYING;
            end
            else if (now == CELL_DYING)
            begin
                res = CELL_OFF;
            end
            else
            begin
                res = (cnt == 4'd2) ? CELL_FIRING : CELL_OFF;
            end
            new_row[2*x +: 2] = res;
            if (x_used && y_used && (res != now))
            begin
                row_chg = 1'b1;
            end
        end
    end

    // cell access helpers
    assign stored_val = (val_reg == 2'd3) ? CELL_OFF : val_reg;
    assign read_val   = rd_data[{col_reg, 1'b0} +: 2];
    assign accept     = start && (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        row_cnt_next    = row_cnt_reg;
        bank_next       = bank_reg;
        chg_next        = chg_reg;
        done_next       = 1'b0;
        cmd_next        = cmd_reg;
        col_next        = col_reg;
        val_next        = val_reg;
        up_next         = up_reg;
        mid_next        = mid_reg;
        dn_next         = dn_reg;
        cell_state_next = cell_state_reg;
        intensity_next  = intensity_reg;
        changed_next    = changed_reg;
        in_range_next   = in_range_reg;
        rd_en           = 1'b0;
        rd_addr         = row_cnt_reg;
        wr_en           = 1'b0;
        wr_bank         = bank_reg;
        wr_addr         = row_cnt_reg;
        wr_data         = new_row;

        case (state_reg)
            ST_CLEAR:
            begin
                // clear the live bank one row a cycle
                wr_en   = 1'b1;
                wr_data = '0;
                if (row_cnt_reg == LAST_ROW)
                begin
                    row_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + ROW_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    col_next = col_pos[COL_W-1:0];
                    val_next = cell_value;
                    if (command == CMD_ADVANCE)
                    begin
                        state_next   = ST_ADV;
                        phase_next   = PH_UP;
                        row_cnt_next = '0;
                        chg_next     = 1'b0;
                    end
                    else if (((command == CMD_WRITE) || (command == CMD_READ)) && in_grid)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = row_pos[ROW_W-1:0];
                        wr_addr    = row_pos[ROW_W-1:0];
                        row_cnt_next = row_pos[ROW_W-1:0];
                        state_next = ST_CELL;
                    end
                    else
                    begin
                        // nothing to touch: empty result beat
                        done_next       = 1'b1;
                        cell_state_next = CELL_OFF;
                        intensity_next  = '0;
                        changed_next    = 1'b0;
                        in_range_next   = 1'b0;
                    end
                end
            end
            ST_CELL:
            begin
                // row data is back: modify and write, or pick the cell
                done_next     = 1'b1;
                changed_next  = 1'b0;
                in_range_next = 1'b1;
                state_next    = ST_IDLE;
                if (cmd_reg == CMD_WRITE)
                begin
                    wr_en   = 1'b1;
                    wr_bank = bank_reg;
                    wr_data = rd_data;
                    wr_data[{col_reg, 1'b0} +: 2] = stored_val;
                    cell_state_next = stored_val;
                    intensity_next  = level_of(stored_val);
                end
                else
                begin
                    cell_state_next = read_val;
                    intensity_next  = level_of(read_val);
                end
            end
            ST_ADV:
            begin
                case (phase_reg)
                    PH_UP:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = up_idx;
                        phase_next = PH_MID;
                    end
                    PH_MID:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = row_cnt_reg;
                        up_next    = up_ok ? rd_data : '0;
                        phase_next = PH_DN;
                    end
                    PH_DN:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = dn_idx;
                        mid_next   = rd_data;
                        phase_next = PH_CAP;
                    end
                    PH_CAP:
                    begin
                        dn_next    = dn_ok ? rd_data : '0;
                        phase_next = PH_CALC;
                    end
                    PH_CALC:
                    begin
                        // new row goes to the other bank
                        wr_en      = 1'b1;
                        wr_bank    = ~bank_reg;
                        wr_data    = new_row;
                        chg_next   = chg_reg | row_chg;
                        phase_next = PH_UP;
                        if (row_cnt_reg == LAST_ROW)
                        begin
                            row_cnt_next    = '0;
                            bank_next       = ~bank_reg;
                            state_next      = ST_IDLE;
                            done_next       = 1'b1;
                            cell_state_next = CELL_OFF;
                            intensity_next  = '0;
                            changed_next    = chg_reg | row_chg;
                            in_range_next   = 1'b0;
                        end
                        else
                        begin
                            row_cnt_next = row_cnt_reg + ROW_W'(1);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_UP;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        cfg_w_next    = cfg_w_reg;
        cfg_h_next    = cfg_h_reg;
        cfg_wrap_next = cfg_wrap_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  cfg_w_next    = cfg_data;
                CFG_HEIGHT: cfg_h_next    = cfg_data;
                CFG_WRAP:   cfg_wrap_next = cfg_data[0];
                default:    cfg_wrap_next = cfg_wrap_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            phase_reg    <= PH_UP;
            row_cnt_reg  <= '0;
            bank_reg     <= 1'b0;
            chg_reg      <= 1'b0;
            cfg_w_reg    <= CFG_DATA_W'(16);
            cfg_h_reg    <= CFG_DATA_W'(16);
            cfg_wrap_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            row_cnt_reg  <= row_cnt_next;
            bank_reg     <= bank_next;
            chg_reg      <= chg_next;
            cfg_w_reg    <= cfg_w_next;
            cfg_h_reg    <= cfg_h_next;
            cfg_wrap_reg <= cfg_wrap_next;
            done_reg     <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        up_reg         <= up_next;
        mid_reg        <= mid_next;
        dn_reg         <= dn_next;
        cell_state_reg <= cell_state_next;
        intensity_reg  <= intensity_next;
        changed_reg    <= changed_next;
        in_range_reg   <= in_range_next;
    end

    // ports
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cell_state = cell_state_reg;
    assign intensity  = intensity_reg;
    assign changed    = changed_reg;
    assign in_range   = in_range_reg;

endmodule

// ===== src/tsca_checker.sv =====
// tsca_checker: port-level assertions for the three-state cell grid, bound to its top level
// depends on tsca_pkg and three_state_cell_automaton_grid
module tsca_checker
    import tsca_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [1:0]            cell_state,
    input logic [15:0]           intensity,
    input logic                  changed,
    input logic                  in_range
);

    // a result beat ends the work, so the block is free again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while busy");

    // an accepted beat leads to work or to an immediate result
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy || done))
        else $error("accepted beat neither started work nor gave a result");

    // a result with in_range low reports no cell: off state, zero intensity
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> ((cell_state == CELL_OFF) && (intensity == 16'd0)))
        else $error("out of range result carries a cell");

    // intensity follows the reported state
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_range) |-> (((cell_state == CELL_FIRING) && (intensity == FULL_LEVEL))
            || ((cell_state == CELL_DYING) && (intensity == DIM_LEVEL))
            || ((cell_state == CELL_OFF) && (intensity == 16'd0))))
        else $error("intensity does not match cell state");

    // change flag only on an advance result
    assert property (@(posedge clk) disable iff (!rst_n) (done && changed) |-> !in_range)
        else $error("change flag on a cell access result");

endmodule

bind three_state_cell_automaton_grid tsca_checker u_tsca_checker (.*);
